>>> hw/rtl/hsrs_pkg.sv
`default_nettype none

package hsrs_pkg;

    // defaults for the top level parameters
    localparam int DEF_MAX_ROW_POINTS = 1024;
    localparam int DEF_VALUE_BITS     = 32;

    // register and field widths
    localparam int ROW_LENGTH_W   = 11;
    localparam int LOCAL_ROWS_W   = 13;
    localparam int GAIN_W         = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;
    localparam int RESIDUAL_W     = 64;
    localparam int FRAC_BITS      = 16;
    localparam int SQ_IN_W        = 32;
    localparam int LAP_EXTRA_BITS = 3;

    // limits of the row walk
    localparam int MIN_ROW_LENGTH  = 3;
    localparam int MAX_LOCAL_ROWS  = 4096;
    localparam int FIRST_LOCAL_ROW = 2;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_LENGTH     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_LOCAL_ROWS     = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TOP_FIXED      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BOTTOM_FIXED   = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_DIFFUSION_GAIN = 3'd4;

    // reset values of the configuration registers
    localparam logic [ROW_LENGTH_W-1:0] RST_ROW_LENGTH = 11'd1024;
    localparam logic [LOCAL_ROWS_W-1:0] RST_LOCAL_ROWS = 13'd1;

    // per point control that travels down the update pipe
    typedef struct packed {
        logic copy;
        logic last;
    } t_ctl;

endpackage

`default_nettype wire

>>> hw/rtl/heat_stencil_row_stream.sv
`default_nettype none

// Five-point Jacobi heat step over a raster stream. Feed old Q16.16 grid
// values row by row: one upper halo row, local_rows local rows, one lower
// halo row, each row_length points wide. Every point of a local row comes
// out one row later as centre + c*(four neighbours - 4*centre), rounded to
// nearest and saturated; edge columns, and the first or last local row when
// top_fixed or bottom_fixed is set, are passed through unchanged. The item
// that completes the block carries last=1 and the saturated Q32.32 sum of
// squared changes; residual reads zero on every other item. No result
// comes out while the two halo-leading rows arrive. The block takes one
// item per clock while not stalled, set by the single read port of each row
// RAM; the centre RAM is read one column ahead of the stream. A result passes
// the laplacian register, which loads on the edge that takes its item, then
// the multiply, round/saturate, change and square stages of the update pipe
// and the output register. A held result stalls the whole update pipe and
// with it the input. After reset and after every register write, the row
// RAM prefetch steps through FILL_CUR and FILL_NXT before the next item is
// taken. Registers must be written only while the block is idle; the block
// does not enforce this. The live values are clamped to their legal ranges
// when used. The row RAMs are not cleared after reset.
module heat_stencil_row_stream
    import hsrs_pkg::*;
#(
    parameter int MAX_ROW_POINTS = DEF_MAX_ROW_POINTS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration write channel
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // old values in
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_BITS-1:0]  i_old_value,
    // new values out
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [VALUE_BITS-1:0]  o_new_value,
    output logic                        o_last,
    output logic      [RESIDUAL_W-1:0]  o_residual
);

    localparam int LAP_W = VALUE_BITS + LAP_EXTRA_BITS;

    // configuration registers
    logic [ROW_LENGTH_W-1:0] r_row_length;
    logic [LOCAL_ROWS_W-1:0] r_local_rows;
    logic                    r_top_fixed;
    logic                    r_bottom_fixed;
    logic [GAIN_W-1:0]       r_gain;

    logic                    cfg_wr;
    logic                    pipe_en;
    logic                    item_valid;
    logic [VALUE_BITS-1:0]   item_cur;
    logic [LAP_W-1:0]        item_lap;
    t_ctl                    item_ctl;

    // register writes are always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_wr      = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length   <= RST_ROW_LENGTH;
            r_local_rows   <= RST_LOCAL_ROWS;
            r_top_fixed    <= 1'b0;
            r_bottom_fixed <= 1'b0;
            r_gain         <= '0;
        end else if (cfg_wr) begin
            case (i_cfg_index)
                REG_ROW_LENGTH:     r_row_length   <= i_cfg_data[ROW_LENGTH_W-1:0];
                REG_LOCAL_ROWS:     r_local_rows   <= i_cfg_data[LOCAL_ROWS_W-1:0];
                REG_TOP_FIXED:      r_top_fixed    <= i_cfg_data[0];
                REG_BOTTOM_FIXED:   r_bottom_fixed <= i_cfg_data[0];
                REG_DIFFUSION_GAIN: r_gain         <= i_cfg_data[GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    // row walk, row RAMs and stencil operand gathering
    hsrs_walker #(
        .MAX_ROW_POINTS (MAX_ROW_POINTS),
        .VALUE_BITS     (VALUE_BITS)
    ) u_walker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_wr       (cfg_wr),
        .i_row_length   (r_row_length),
        .i_local_rows   (r_local_rows),
        .i_top_fixed    (r_top_fixed),
        .i_bottom_fixed (r_bottom_fixed),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_old_value    (i_old_value),
        .i_pipe_en      (pipe_en),
        .o_item_valid   (item_valid),
        .o_cur          (item_cur),
        .o_lap          (item_lap),
        .o_ctl          (item_ctl)
    );

    // gain multiply, rounding, saturation and residual
    hsrs_update_pipe #(
        .VALUE_BITS (VALUE_BITS)
    ) u_pipe (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_gain       (r_gain),
        .o_en         (pipe_en),
        .i_item_valid (item_valid),
        .i_cur        (item_cur),
        .i_lap        (item_lap),
        .i_ctl        (item_ctl),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_new_value  (o_new_value),
        .o_last       (o_last),
        .o_residual   (o_residual)
    );

endmodule

`default_nettype wire

>>> hw/rtl/hsrs_row_ram.sv
`default_nettype none

module hsrs_row_ram #(
    parameter int DEPTH  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

`default_nettype wire

>>> hw/rtl/hsrs_walker.sv
`default_nettype none

module hsrs_walker
    import hsrs_pkg::*;
#(
    parameter int MAX_ROW_POINTS = DEF_MAX_ROW_POINTS,
    parameter int VALUE_BITS     = DEF_VALUE_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_cfg_wr,
    input  wire logic [ROW_LENGTH_W-1:0]              i_row_length,
    input  wire logic [LOCAL_ROWS_W-1:0]              i_local_rows,
    input  wire logic                                 i_top_fixed,
    input  wire logic                                 i_bottom_fixed,
    input  wire logic                                 i_valid,
    output logic                                      o_ready,
    input  wire logic [VALUE_BITS-1:0]                i_old_value,
    input  wire logic                                 i_pipe_en,
    output logic                                      o_item_valid,
    output logic      [VALUE_BITS-1:0]                o_cur,
    output logic      [VALUE_BITS+LAP_EXTRA_BITS-1:0] o_lap,
    output t_ctl                                      o_ctl
);

    localparam int ADDR_W = $clog2(MAX_ROW_POINTS);
    localparam int LEN_CW = $clog2(MAX_ROW_POINTS + 1);
    localparam int LEN_W  = (LEN_CW > ROW_LENGTH_W) ? LEN_CW : ROW_LENGTH_W;
    localparam int ROWS_W = LOCAL_ROWS_W + 1;
    localparam int LAP_W  = VALUE_BITS + LAP_EXTRA_BITS;

    localparam logic [LEN_W-1:0]  LEN_MIN  = LEN_W'(MIN_ROW_LENGTH);
    localparam logic [LEN_W-1:0]  LEN_MAX  = LEN_W'(MAX_ROW_POINTS);
    localparam logic [ROWS_W-1:0] ROWS_MIN = ROWS_W'(1);
    localparam logic [ROWS_W-1:0] ROWS_MAX = ROWS_W'(MAX_LOCAL_ROWS);

    // prefetch states
    localparam logic [1:0] FILL_CUR = 2'd0;
    localparam logic [1:0] FILL_NXT = 2'd1;
    localparam logic [1:0] FILL_RUN = 2'd2;

    logic [1:0]              r_fill, n_fill;
    logic [ADDR_W-1:0]       r_col, n_col;
    logic [LOCAL_ROWS_W-1:0] r_row, n_row;
    logic [VALUE_BITS-1:0]   r_cur, n_cur;
    logic [VALUE_BITS-1:0]   r_left;
    logic [VALUE_BITS-1:0]   r_col0;

    logic [LEN_W-1:0]        len_raw, len_c, len_m1;
    logic [ROWS_W-1:0]       rows_raw, rows_c;
    logic [ADDR_W-1:0]       col_c, rd_col, ct_raddr;
    logic                    row_end, final_row, emit, acc;
    logic [VALUE_BITS-1:0]   up_q, ct_q, right;
    logic signed [LAP_W-1:0] up_x, dn_x, lf_x, rt_x, cur_x, lap;

    // clamp the live registers
    always_comb begin
        len_raw = LEN_W'(i_row_length);
        if (len_raw < LEN_MIN) begin
            len_c = LEN_MIN;
        end else if (len_raw > LEN_MAX) begin
            len_c = LEN_MAX;
        end else begin
            len_c = len_raw;
        end
        len_m1 = len_c - LEN_W'(1);

        rows_raw = ROWS_W'(i_local_rows);
        if (rows_raw < ROWS_MIN) begin
            rows_c = ROWS_MIN;
        end else if (rows_raw > ROWS_MAX) begin
            rows_c = ROWS_MAX;
        end else begin
            rows_c = rows_raw;
        end

        if (LEN_W'(r_col) > len_m1) begin
            col_c = len_m1[ADDR_W-1:0];
        end else begin
            col_c = r_col;
        end
    end

    assign row_end   = (LEN_W'(col_c) == len_m1);
    assign final_row = (ROWS_W'(r_row) >= rows_c + ROWS_W'(1));
    assign emit      = (r_row >= LOCAL_ROWS_W'(FIRST_LOCAL_ROW));
    assign o_ready   = (r_fill == FILL_RUN) && i_pipe_en;
    assign acc       = i_valid && o_ready;

    // stencil operands
    assign right = row_end ? '0 : ct_q;
    assign up_x  = {{LAP_EXTRA_BITS{up_q[VALUE_BITS-1]}}, up_q};
    assign dn_x  = {{LAP_EXTRA_BITS{i_old_value[VALUE_BITS-1]}}, i_old_value};
    assign lf_x  = {{LAP_EXTRA_BITS{r_left[VALUE_BITS-1]}}, r_left};
    assign rt_x  = {{LAP_EXTRA_BITS{right[VALUE_BITS-1]}}, right};
    assign cur_x = {{LAP_EXTRA_BITS{r_cur[VALUE_BITS-1]}}, r_cur};
    assign lap   = up_x + dn_x + lf_x + rt_x - (cur_x <<< 2);

    assign o_item_valid = acc && emit;
    assign o_cur        = r_cur;
    assign o_lap        = lap;
    assign o_ctl.copy   = (col_c == '0) || row_end
                          || (i_top_fixed && (r_row == LOCAL_ROWS_W'(FIRST_LOCAL_ROW)))
                          || (i_bottom_fixed && final_row);
    assign o_ctl.last   = final_row && row_end;

    // walk and prefetch
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        n_cur = r_cur;
        if (acc) begin
            if (row_end) begin
                n_col = '0;
                n_row = final_row ? '0 : r_row + LOCAL_ROWS_W'(1);
                n_cur = r_col0;
            end else begin
                n_col = col_c + ADDR_W'(1);
                n_cur = ct_q;
            end
        end else if (r_fill == FILL_NXT) begin
            n_cur = ct_q;
        end

        case (r_fill)
            FILL_CUR: n_fill = FILL_NXT;
            FILL_NXT: n_fill = FILL_RUN;
            FILL_RUN: n_fill = FILL_RUN;
            default:  n_fill = FILL_CUR;
        endcase
        if (i_cfg_wr) begin
            n_fill = FILL_CUR;
        end

        rd_col = acc ? n_col : col_c;
        if (r_fill == FILL_CUR) begin
            ct_raddr = col_c;
        end else begin
            ct_raddr = rd_col + ADDR_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= FILL_CUR;
            r_col  <= '0;
            r_row  <= '0;
        end else begin
            r_fill <= n_fill;
            r_col  <= n_col;
            r_row  <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (acc) begin
            r_left <= r_cur;
            if (col_c == '0) begin
                r_col0 <= i_old_value;
            end
        end
    end

    hsrs_row_ram #(
        .DEPTH  (MAX_ROW_POINTS),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (ADDR_W)
    ) u_upper (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (col_c),
        .i_wdata (r_cur),
        .i_raddr (rd_col),
        .o_rdata (up_q)
    );

    hsrs_row_ram #(
        .DEPTH  (MAX_ROW_POINTS),
        .WIDTH  (VALUE_BITS),
        .ADDR_W (ADDR_W)
    ) u_centre (
        .i_clk   (i_clk),
        .i_we    (acc),
        .i_waddr (col_c),
        .i_wdata (i_old_value),
        .i_raddr (ct_raddr),
        .o_rdata (ct_q)
    );

    a_acc_when_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |-> (r_fill == FILL_RUN))
        else $error("item taken before row store prefetch finished");

    a_cfg_refill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_wr |=> !o_ready)
        else $error("item taken right after a register write");

    a_row_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (acc && row_end) |=> (r_col == '0))
        else $error("column count did not wrap at row end");

endmodule

`default_nettype wire

>>> hw/rtl/hsrs_update_pipe.sv
`default_nettype none

module hsrs_update_pipe
    import hsrs_pkg::*;
#(
    parameter int VALUE_BITS = DEF_VALUE_BITS
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic [GAIN_W-1:0]                    i_gain,
    output logic                                      o_en,
    input  wire logic                                 i_item_valid,
    input  wire logic [VALUE_BITS-1:0]                i_cur,
    input  wire logic [VALUE_BITS+LAP_EXTRA_BITS-1:0] i_lap,
    input  wire t_ctl                                 i_ctl,
    output logic                                      o_valid,
    input  wire logic                                 i_ready,
    output logic      [VALUE_BITS-1:0]                o_new_value,
    output logic                                      o_last,
    output logic      [RESIDUAL_W-1:0]                o_residual
);

    localparam int LAP_W  = VALUE_BITS + LAP_EXTRA_BITS;
    localparam int PROD_W = LAP_W + GAIN_W + 1;
    localparam int RND_W  = PROD_W - FRAC_BITS;
    localparam int SUM_W  = VALUE_BITS + 5;
    localparam int MAG_W  = VALUE_BITS + 1;
    localparam int TOP_W  = SUM_W - VALUE_BITS + 1;

    localparam logic [PROD_W-1:0]     HALF = PROD_W'(1) << (FRAC_BITS - 1);
    localparam logic [VALUE_BITS-1:0] VMAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VMIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    logic en;

    // stage 1: laplacian
    logic                  r_s1_v;
    logic [LAP_W-1:0]      r_s1_lap;
    logic [VALUE_BITS-1:0] r_s1_cur;
    t_ctl                  r_s1_ctl;
    // stage 2: gain product
    logic                  r_s2_v;
    logic [PROD_W-1:0]     r_s2_prod;
    logic [VALUE_BITS-1:0] r_s2_cur;
    t_ctl                  r_s2_ctl;
    // stage 3: new value
    logic                  r_s3_v;
    logic [VALUE_BITS-1:0] r_s3_nv;
    logic [VALUE_BITS-1:0] r_s3_cur;
    logic                  r_s3_last;
    // stage 4: change magnitude
    logic                  r_s4_v;
    logic [VALUE_BITS-1:0] r_s4_nv;
    logic [SQ_IN_W-1:0]    r_s4_m32;
    logic                  r_s4_big;
    logic                  r_s4_last;
    // stage 5: square
    logic                  r_s5_v;
    logic [VALUE_BITS-1:0] r_s5_nv;
    logic [RESIDUAL_W-1:0] r_s5_sq;
    logic                  r_s5_big;
    logic                  r_s5_last;
    // output register and running sum
    logic                  r_out_v;
    logic [VALUE_BITS-1:0] r_out_nv;
    logic                  r_out_last;
    logic [RESIDUAL_W-1:0] r_out_res;
    logic [RESIDUAL_W-1:0] r_sum;

    logic signed [PROD_W-1:0] gain_x, lap_x, prod;
    logic [PROD_W-1:0]        rnd_q;
    logic [RND_W-1:0]         rnd;
    logic [SUM_W-1:0]         vsum;
    logic [TOP_W-1:0]         vtop;
    logic [VALUE_BITS-1:0]    sat, nv;
    logic [MAG_W-1:0]         dif, mag;
    logic [MAG_W+SQ_IN_W-1:0] mag_x;
    logic [RESIDUAL_W-1:0]    sq;
    logic [RESIDUAL_W:0]      acc_sum;
    logic [RESIDUAL_W-1:0]    new_sum;

    assign en   = !r_out_v || i_ready;
    assign o_en = en;

    // gain times laplacian, exact
    assign gain_x = {{(PROD_W-GAIN_W){1'b0}}, i_gain};
    assign lap_x  = {{(PROD_W-LAP_W){r_s1_lap[LAP_W-1]}}, r_s1_lap};
    assign prod   = gain_x * lap_x;

    // round to nearest, ties up, then saturating add
    always_comb begin
        rnd_q = r_s2_prod + HALF;
        rnd   = rnd_q[PROD_W-1:FRAC_BITS];
        vsum  = {{(SUM_W-VALUE_BITS){r_s2_cur[VALUE_BITS-1]}}, r_s2_cur}
                + {{(SUM_W-RND_W){rnd[RND_W-1]}}, rnd};
        vtop  = vsum[SUM_W-1:VALUE_BITS-1];
        if ((vtop == '0) || (vtop == '1)) begin
            sat = vsum[VALUE_BITS-1:0];
        end else if (vsum[SUM_W-1]) begin
            sat = VMIN;
        end else begin
            sat = VMAX;
        end
        nv = r_s2_ctl.copy ? r_s2_cur : sat;
    end

    // magnitude of the change
    always_comb begin
        dif   = {r_s3_nv[VALUE_BITS-1], r_s3_nv} - {r_s3_cur[VALUE_BITS-1], r_s3_cur};
        mag   = dif[MAG_W-1] ? (MAG_W'(0) - dif) : dif;
        mag_x = {{SQ_IN_W{1'b0}}, mag};
    end

    // saturating residual sum
    always_comb begin
        sq      = r_s5_big ? '1 : r_s5_sq;
        acc_sum = {1'b0, r_sum} + {1'b0, sq};
        new_sum = acc_sum[RESIDUAL_W] ? '1 : acc_sum[RESIDUAL_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v  <= 1'b0;
            r_s2_v  <= 1'b0;
            r_s3_v  <= 1'b0;
            r_s4_v  <= 1'b0;
            r_s5_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_sum   <= '0;
        end else if (en) begin
            r_s1_v  <= i_item_valid;
            r_s2_v  <= r_s1_v;
            r_s3_v  <= r_s2_v;
            r_s4_v  <= r_s3_v;
            r_s5_v  <= r_s4_v;
            r_out_v <= r_s5_v;
            if (r_s5_v) begin
                r_sum <= r_s5_last ? '0 : new_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_lap   <= i_lap;
            r_s1_cur   <= i_cur;
            r_s1_ctl   <= i_ctl;
            r_s2_prod  <= prod;
            r_s2_cur   <= r_s1_cur;
            r_s2_ctl   <= r_s1_ctl;
            r_s3_nv    <= nv;
            r_s3_cur   <= r_s2_cur;
            r_s3_last  <= r_s2_ctl.last;
            r_s4_nv    <= r_s3_nv;
            r_s4_m32   <= mag_x[SQ_IN_W-1:0];
            r_s4_big   <= |mag_x[MAG_W+SQ_IN_W-1:SQ_IN_W];
            r_s4_last  <= r_s3_last;
            r_s5_nv    <= r_s4_nv;
            r_s5_sq    <= RESIDUAL_W'(r_s4_m32) * RESIDUAL_W'(r_s4_m32);
            r_s5_big   <= r_s4_big;
            r_s5_last  <= r_s4_last;
            r_out_nv   <= r_s5_nv;
            r_out_last <= r_s5_last;
            r_out_res  <= r_s5_last ? new_sum : '0;
        end
    end

    assign o_valid     = r_out_v;
    assign o_new_value = r_out_nv;
    assign o_last      = r_out_last;
    assign o_residual  = r_out_res;

    a_res_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_v && !r_out_last) |-> (r_out_res == '0))
        else $error("residual shown on a point that is not the last");

    a_sum_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_s5_v && r_s5_last) |=> (r_sum == '0))
        else $error("residual sum not cleared at block end");

    a_enter_moving: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_item_valid |-> en)
        else $error("point entered a stalled pipe");

endmodule

`default_nettype wire
